>>> hw/rtl/bsr_pkg.sv
`timescale 1ns / 1ps

package bsr_pkg;

    // Field widths
    localparam int DIM_W   = 13;
    localparam int POS_W   = 32;
    localparam int RGBA_W  = 32;
    localparam int INDEX_W = 24;
    localparam int PB_W    = 24;

    // Header byte positions
    localparam logic [4:0] POS_MAGIC0  = 5'd0;
    localparam logic [4:0] POS_MAGIC1  = 5'd1;
    localparam logic [4:0] POS_OFF0    = 5'd10;
    localparam logic [4:0] POS_OFF3    = 5'd13;
    localparam logic [4:0] POS_WIDTH0  = 5'd18;
    localparam logic [4:0] POS_WIDTH1  = 5'd19;
    localparam logic [4:0] POS_WIDTH3  = 5'd21;
    localparam logic [4:0] POS_HEIGHT0 = 5'd22;
    localparam logic [4:0] POS_HEIGHT1 = 5'd23;
    localparam logic [4:0] POS_HEIGHT3 = 5'd25;
    localparam logic [4:0] POS_BPP0    = 5'd28;
    localparam logic [4:0] POS_HDR_END = 5'd29;

    // Magic and pixel constants
    localparam logic [7:0] MAGIC_B      = 8'h42;
    localparam logic [7:0] MAGIC_M      = 8'h4D;
    localparam logic [7:0] DEPTH_32     = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC  = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE   = 2'd2;
    localparam logic [1:0] ST_BAD_OFFSET = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_PIXELS = 2'd2,
        PH_HALT   = 2'd3
    } t_phase;

    // Decoded pixel handed from the parser to the index stage
    typedef struct packed {
        logic [RGBA_W-1:0] rgba;
        logic [DIM_W-1:0]  dest_row;
        logic [DIM_W-1:0]  column;
        logic [DIM_W-1:0]  width;
        logic              last;
        logic [1:0]        status;
    } t_pix_item;

endpackage

>>> hw/rtl/bsr_in_if.sv
`timescale 1ns / 1ps

interface bsr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       start_of_file;

    modport source (output valid, output file_byte, output start_of_file, input ready);
    modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

>>> hw/rtl/bsr_out_if.sv
`timescale 1ns / 1ps

interface bsr_out_if;
    logic                          valid;
    logic                          ready;
    logic [bsr_pkg::RGBA_W-1:0]    pixel_rgba;
    logic [bsr_pkg::INDEX_W-1:0]   pixel_index;
    logic                          last_pixel;
    logic [1:0]                    status;

    modport source (output valid, output pixel_rgba, output pixel_index,
                    output last_pixel, output status, input ready);
    modport sink   (input valid, input pixel_rgba, input pixel_index,
                    input last_pixel, input status, output ready);
endinterface

>>> hw/rtl/bsr_parser.sv
`timescale 1ns / 1ps

module bsr_parser #(
    parameter int MAX_DIM = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_file_byte,
    input  logic                 i_start,
    input  logic                 i_vflip,
    output logic                 o_valid,
    output bsr_pkg::t_pix_item   o_item,
    input  logic                 i_ready
);

    localparam int DW = bsr_pkg::DIM_W;
    localparam int PW = bsr_pkg::POS_W;

    // Parser state
    logic [PW-1:0]              r_pos, n_pos;
    logic [PW-1:0]              r_off, n_off;
    logic [DW-1:0]              r_width, n_width;
    logic [DW-1:0]              r_height, n_height;
    logic                       r_four, n_four;
    logic [DW-1:0]              r_col, n_col;
    logic [DW-1:0]              r_row, n_row;
    logic [bsr_pkg::PB_W-1:0]   r_pb, n_pb;
    logic [1:0]                 r_bip, n_bip;
    bsr_pkg::t_phase            r_phase, n_phase;
    logic                       r_size_bad, n_size_bad;

    // Result register
    logic                       r_valid;
    bsr_pkg::t_pix_item         r_item, n_item;
    logic                       n_has_result;

    // Current state after an optional restart
    logic [PW-1:0]              c_pos, c_off;
    logic [DW-1:0]              c_width, c_height, c_col, c_row;
    logic                       c_four, c_size_bad;
    logic [bsr_pkg::PB_W-1:0]   c_pb;
    logic [1:0]                 c_bip;
    bsr_pkg::t_phase            c_phase;

    logic [4:0]                 pos_lo;
    logic [4:0]                 off_lane;
    logic [15:0]                dim_full;
    logic [1:0]                 final_bip;
    logic [7:0]                 red, green, blue, alpha;
    logic [DW-1:0]              col_inc;
    logic                       in_fire;

    assign in_fire = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Restart mux
    always_comb begin
        if (i_start) begin
            c_pos      = '0;
            c_off      = '0;
            c_width    = '0;
            c_height   = '0;
            c_four     = 1'b0;
            c_col      = '0;
            c_row      = '0;
            c_pb       = '0;
            c_bip      = '0;
            c_phase    = bsr_pkg::PH_HEADER;
            c_size_bad = 1'b0;
        end else begin
            c_pos      = r_pos;
            c_off      = r_off;
            c_width    = r_width;
            c_height   = r_height;
            c_four     = r_four;
            c_col      = r_col;
            c_row      = r_row;
            c_pb       = r_pb;
            c_bip      = r_bip;
            c_phase    = r_phase;
            c_size_bad = r_size_bad;
        end
    end

    // Byte decode
    always_comb begin
        n_pos        = c_pos + 1'b1;
        n_off        = c_off;
        n_width      = c_width;
        n_height     = c_height;
        n_four       = c_four;
        n_col        = c_col;
        n_row        = c_row;
        n_pb         = c_pb;
        n_bip        = c_bip;
        n_phase      = c_phase;
        n_size_bad   = c_size_bad;
        n_has_result = 1'b0;
        n_item       = '0;
        pos_lo       = c_pos[4:0];
        off_lane     = pos_lo - bsr_pkg::POS_OFF0;
        dim_full     = '0;
        final_bip    = c_four ? 2'd3 : 2'd2;
        red          = '0;
        green        = '0;
        blue         = '0;
        alpha        = '0;
        col_inc      = c_col + 1'b1;

        case (c_phase)
            bsr_pkg::PH_HEADER: begin
                // Header phase only spans positions 0..29
                if (pos_lo == bsr_pkg::POS_MAGIC0) begin
                    n_pb = {16'd0, i_file_byte};
                end else if (pos_lo == bsr_pkg::POS_MAGIC1) begin
                    n_pb = '0;
                    if (c_pb[7:0] != bsr_pkg::MAGIC_B || c_pb[23:8] != 16'd0 ||
                        i_file_byte != bsr_pkg::MAGIC_M) begin
                        n_phase      = bsr_pkg::PH_HALT;
                        n_has_result = 1'b1;
                        n_item.status = bsr_pkg::ST_BAD_MAGIC;
                        n_pb         = c_pb;
                    end
                end else if (pos_lo >= bsr_pkg::POS_OFF0 && pos_lo <= bsr_pkg::POS_OFF3) begin
                    n_off[8*off_lane[1:0] +: 8] = c_off[8*off_lane[1:0] +: 8] | i_file_byte;
                end else if (pos_lo == bsr_pkg::POS_WIDTH0) begin
                    n_width = {{(DW-8){1'b0}}, i_file_byte};
                end else if (pos_lo == bsr_pkg::POS_WIDTH1) begin
                    dim_full = {i_file_byte, 8'd0} | {{(16-DW){1'b0}}, c_width};
                    if (dim_full > 16'(MAX_DIM)) n_size_bad = 1'b1;
                    n_width = dim_full[DW-1:0];
                end else if (pos_lo > bsr_pkg::POS_WIDTH1 && pos_lo <= bsr_pkg::POS_WIDTH3) begin
                    if (i_file_byte != 8'd0) n_size_bad = 1'b1;
                end else if (pos_lo == bsr_pkg::POS_HEIGHT0) begin
                    n_height = {{(DW-8){1'b0}}, i_file_byte};
                end else if (pos_lo == bsr_pkg::POS_HEIGHT1) begin
                    dim_full = {i_file_byte, 8'd0} | {{(16-DW){1'b0}}, c_height};
                    if (dim_full > 16'(MAX_DIM)) n_size_bad = 1'b1;
                    n_height = dim_full[DW-1:0];
                end else if (pos_lo > bsr_pkg::POS_HEIGHT1 && pos_lo <= bsr_pkg::POS_HEIGHT3) begin
                    if (i_file_byte != 8'd0) n_size_bad = 1'b1;
                end else if (pos_lo == bsr_pkg::POS_BPP0) begin
                    n_four = (i_file_byte == bsr_pkg::DEPTH_32);
                end else if (pos_lo == bsr_pkg::POS_HDR_END) begin
                    if (i_file_byte != 8'd0) n_four = 1'b0;
                    if (c_size_bad) begin
                        n_phase       = bsr_pkg::PH_HALT;
                        n_has_result  = 1'b1;
                        n_item.status = bsr_pkg::ST_BAD_SIZE;
                    end else if (c_off <= PW'(bsr_pkg::POS_HDR_END)) begin
                        n_phase       = bsr_pkg::PH_HALT;
                        n_has_result  = 1'b1;
                        n_item.status = bsr_pkg::ST_BAD_OFFSET;
                    end else if (c_width == '0 || c_height == '0) begin
                        n_phase = bsr_pkg::PH_HALT;
                    end else if (c_off == PW'(bsr_pkg::POS_HDR_END) + 1'b1) begin
                        n_phase = bsr_pkg::PH_PIXELS;
                    end else begin
                        n_phase = bsr_pkg::PH_SKIP;
                    end
                end
            end
            bsr_pkg::PH_SKIP, bsr_pkg::PH_PIXELS: begin
                // The byte at the data offset is already pixel data
                if (c_phase == bsr_pkg::PH_PIXELS || c_pos == c_off) begin
                    n_phase = bsr_pkg::PH_PIXELS;
                    if (c_bip < final_bip) begin
                        n_pb[8*c_bip +: 8] = c_pb[8*c_bip +: 8] | i_file_byte;
                        n_bip = c_bip + 1'b1;
                    end else begin
                        blue  = c_pb[7:0];
                        green = c_pb[15:8];
                        if (c_four) begin
                            red   = c_pb[23:16];
                            alpha = i_file_byte;
                        end else begin
                            red   = i_file_byte;
                            alpha = bsr_pkg::ALPHA_OPAQUE;
                        end
                        n_pb  = '0;
                        n_bip = '0;
                        n_has_result    = 1'b1;
                        n_item.rgba     = {alpha, blue, green, red};
                        n_item.dest_row = i_vflip ? (c_height - 1'b1 - c_row) : c_row;
                        n_item.column   = c_col;
                        n_item.width    = c_width;
                        n_item.last     = (c_row == c_height - 1'b1) &&
                                          (c_col == c_width - 1'b1);
                        n_item.status   = bsr_pkg::ST_OK;
                        if (col_inc >= c_width) begin
                            n_col = '0;
                            n_row = c_row + 1'b1;
                        end else begin
                            n_col = col_inc;
                        end
                        if (n_item.last) n_phase = bsr_pkg::PH_HALT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_off      <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_four     <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_pb       <= '0;
            r_bip      <= '0;
            r_phase    <= bsr_pkg::PH_HEADER;
            r_size_bad <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_pos      <= n_pos;
                r_off      <= n_off;
                r_width    <= n_width;
                r_height   <= n_height;
                r_four     <= n_four;
                r_col      <= n_col;
                r_row      <= n_row;
                r_pb       <= n_pb;
                r_bip      <= n_bip;
                r_phase    <= n_phase;
                r_size_bad <= n_size_bad;
                r_valid    <= n_has_result;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= n_item;
        end
    end

endmodule

>>> hw/rtl/bsr_index.sv
`timescale 1ns / 1ps

module bsr_index (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bsr_pkg::t_pix_item            i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bsr_pkg::RGBA_W-1:0]    o_rgba,
    output logic [bsr_pkg::INDEX_W-1:0]   o_index,
    output logic                          o_last,
    output logic [1:0]                    o_status
);

    localparam int DW = bsr_pkg::DIM_W;

    logic                          r_valid;
    logic [bsr_pkg::RGBA_W-1:0]    r_rgba;
    logic [bsr_pkg::INDEX_W-1:0]   r_index, n_index;
    logic                          r_last;
    logic [1:0]                    r_status;
    logic [2*DW-1:0]               prod;
    logic [2*DW-1:0]               sum;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_rgba   = r_rgba;
    assign o_index  = r_index;
    assign o_last   = r_last;
    assign o_status = r_status;

    // Destination index: row times width plus column
    always_comb begin
        prod    = i_item.dest_row * i_item.width;
        sum     = prod + {{DW{1'b0}}, i_item.column};
        n_index = sum[bsr_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rgba   <= i_item.rgba;
            r_index  <= n_index;
            r_last   <= i_item.last;
            r_status <= i_item.status;
        end
    end

endmodule

>>> hw/rtl/bmp_stream_to_rgba_unit.sv
`timescale 1ns / 1ps
// Streaming bitmap decoder: bytes of a BMP file in, RGBA pixels out.
// Input channel i_in (valid/ready): one file byte per transaction, with
// start_of_file marking offset zero of a new file. The header is parsed on
// the fly, bytes up to the data offset are dropped, and each completed
// 24-bit or 32-bit pixel yields one output transaction on o_out carrying
// pixel_rgba, pixel_index, last_pixel and status. Header errors give a
// single transaction with a nonzero status, after which bytes are dropped
// until the next start_of_file.
// Throughput: one byte per cycle, sustained while o_out keeps accepting results.
// A result is taken into the parser register at the edge that accepts the
// byte completing it, then into the index multiply register, which drives
// o_out.
// i_cfg_wr_en / i_cfg_wr_data write vertical_flip; write it while idle.
// Reset (i_rst_n low, synchronous) clears the parser to the header phase,
// empties both pipeline registers and clears vertical_flip.
// When o_out stalls, results hold in the output register; the parser
// register keeps one more, and i_in.ready drops only when both are full.
module bmp_stream_to_rgba_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    bsr_in_if.sink     i_in,
    bsr_out_if.source  o_out
);

    logic                  r_vflip;
    logic                  s1_valid;
    logic                  s1_ready;
    bsr_pkg::t_pix_item    s1_item;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vflip <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_vflip <= i_cfg_wr_data;
        end
    end

    // Header parser and pixel assembly
    bsr_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_file_byte (i_in.file_byte),
        .i_start     (i_in.start_of_file),
        .i_vflip     (r_vflip),
        .o_valid     (s1_valid),
        .o_item      (s1_item),
        .i_ready     (s1_ready)
    );

    // Index computation and output register
    bsr_index u_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .o_ready  (s1_ready),
        .i_item   (s1_item),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_rgba   (o_out.pixel_rgba),
        .o_index  (o_out.pixel_index),
        .o_last   (o_out.last_pixel),
        .o_status (o_out.status)
    );

endmodule
